FILE: src/ccc_pkg.sv
`default_nettype none

package ccc_pkg;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_LOAD   = 2'd1,
        FUNC_DATA   = 2'd2,
        FUNC_FINISH = 2'd3
    } func_e_t;

    // chip variant codes
    localparam logic [2:0] VAR_6101 = 3'd0;
    localparam logic [2:0] VAR_6102 = 3'd1;
    localparam logic [2:0] VAR_6103 = 3'd2;
    localparam logic [2:0] VAR_6105 = 3'd3;
    localparam logic [2:0] VAR_6106 = 3'd4;
    localparam logic [2:0] VAR_RESET = VAR_6102;

    localparam logic [31:0] SEED_A = 32'hF8CA4DDC;
    localparam logic [31:0] SEED_B = 32'hA3886759;
    localparam logic [31:0] SEED_C = 32'hDF26F436;
    localparam logic [31:0] SEED_D = 32'h1FEA617A;

    localparam int VAR_W    = 3;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = 19;
    localparam int TBL_WORDS = 64;
    localparam int TBL_AW   = 6;
    localparam int CODE_W   = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // one classified beat on its way from front to back
    typedef struct packed {
        func_e_t            func;
        logic [WORD_W-1:0]  data;
        logic [WORD_W-1:0]  tbl;
    } q_item_t;

    function automatic logic [WORD_W-1:0] seed_of(input logic [VAR_W-1:0] v);
        logic [WORD_W-1:0] s;
        case (v)
            VAR_6103: s = SEED_B;
            VAR_6105: s = SEED_C;
            VAR_6106: s = SEED_D;
            default:  s = SEED_A;
        endcase
        return s;
    endfunction

    // rotate left by the word's own low five bits
    function automatic logic [WORD_W-1:0] rotl_self(input logic [WORD_W-1:0] d);
        logic [2*WORD_W-1:0] dd;
        dd = {d, d} << d[4:0];
        return dd[2*WORD_W-1:WORD_W];
    endfunction

endpackage

`default_nettype wire

FILE: src/ccc_front.sv
`default_nettype none

module ccc_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire ccc_pkg::func_e_t       in_func,
    input  wire logic [31:0]            in_data,
    input  wire logic [5:0]             in_index,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output ccc_pkg::q_item_t            out_item
);

    logic [31:0] tbl_mem [ccc_pkg::TBL_WORDS];
    logic [31:0] tbl_rd_reg;
    logic [ccc_pkg::TBL_AW-1:0] pos_reg, pos_next;
    logic        stg_valid_reg;
    ccc_pkg::func_e_t stg_func_reg;
    logic [31:0] stg_data_reg;
    logic        accept;

    assign in_ready = !stg_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // table port: write on load beats, read slot of the next data word
    always_ff @(posedge clk)
    begin
        if (accept && in_func == ccc_pkg::FUNC_LOAD)
        begin
            tbl_mem[in_index] <= in_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tbl_rd_reg <= tbl_mem[pos_reg];
        end
    end

    // word position mod table size, tracked in beat order
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            unique case (in_func)
                ccc_pkg::FUNC_START:  pos_next = '0;
                ccc_pkg::FUNC_DATA:   pos_next = pos_reg + 1'b1;
                ccc_pkg::FUNC_LOAD:   pos_next = pos_reg;
                ccc_pkg::FUNC_FINISH: pos_next = pos_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (in_ready)
            begin
                stg_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_func_reg <= in_func;
            stg_data_reg <= in_data;
        end
    end

    assign out_valid     = stg_valid_reg;
    assign out_item.func = stg_func_reg;
    assign out_item.data = stg_data_reg;
    assign out_item.tbl  = tbl_rd_reg;

endmodule

`default_nettype wire

FILE: src/ccc_queue.sv
`default_nettype none

module ccc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ccc_pkg::q_item_t   in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ccc_pkg::q_item_t        out_item
);

    ccc_pkg::q_item_t slot_reg [ccc_pkg::QUEUE_DEPTH];
    logic [ccc_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ccc_pkg::QUEUE_AW:0]   fill_reg, fill_next;
    logic push, pop;

    assign in_ready  = fill_reg != (ccc_pkg::QUEUE_AW+1)'(ccc_pkg::QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/ccc_back.sv
`default_nettype none

module ccc_back #(
    parameter int MAX_WORDS = 262144
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [2:0]             variant,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire ccc_pkg::q_item_t       in_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [63:0]                 out_code,
    output logic [18:0]                 out_count
);

    localparam logic [ccc_pkg::CNT_W-1:0] LIMIT = ccc_pkg::CNT_W'(MAX_WORDS);

    logic [31:0] acc_reg [6];
    logic [31:0] acc_next [6];
    logic [ccc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic        out_valid_reg;
    logic [63:0] out_code_reg;
    logic [18:0] out_count_reg;
    logic        out_free, take, emit;
    logic [31:0] d, r;
    logic [32:0] sum5;
    logic [31:0] hi, lo, prod_hi, prod_lo;
    logic [31:0] seed;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (in_item.func != ccc_pkg::FUNC_FINISH) || out_free;
    assign take     = in_valid && in_ready;
    assign emit     = take && in_item.func == ccc_pkg::FUNC_FINISH;

    assign d    = in_item.data;
    assign r    = ccc_pkg::rotl_self(d);
    assign sum5 = {1'b0, acc_reg[5]} + {1'b0, d};
    assign seed = ccc_pkg::seed_of(variant);

    // per-beat accumulator update
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            acc_next[k] = acc_reg[k];
        end
        cnt_next = cnt_reg;
        if (take)
        begin
            unique case (in_item.func)
                ccc_pkg::FUNC_START:
                begin
                    for (int k = 0; k < 6; k++)
                    begin
                        acc_next[k] = seed;
                    end
                    cnt_next = '0;
                end
                ccc_pkg::FUNC_DATA:
                begin
                    if (cnt_reg < LIMIT)
                    begin
                        acc_next[5] = sum5[31:0];
                        acc_next[3] = acc_reg[3] + {31'd0, sum5[32]};
                        acc_next[2] = acc_reg[2] ^ d;
                        acc_next[4] = acc_reg[4] + r;
                        acc_next[1] = (acc_reg[1] > d) ? (acc_reg[1] ^ r)
                                                       : (acc_reg[1] ^ sum5[31:0] ^ d);
                        acc_next[0] = acc_reg[0] + ((variant == ccc_pkg::VAR_6105)
                                                    ? (in_item.tbl ^ d)
                                                    : (acc_next[4] ^ d));
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                ccc_pkg::FUNC_LOAD:   cnt_next = cnt_reg;
                ccc_pkg::FUNC_FINISH: cnt_next = cnt_reg;
            endcase
        end
    end

    // combine rule
    assign prod_hi = acc_reg[5] * acc_reg[3];
    assign prod_lo = acc_reg[4] * acc_reg[1];

    always_comb
    begin
        case (variant)
            ccc_pkg::VAR_6103:
            begin
                hi = (acc_reg[5] ^ acc_reg[3]) + acc_reg[2];
                lo = (acc_reg[4] ^ acc_reg[1]) + acc_reg[0];
            end
            ccc_pkg::VAR_6106:
            begin
                hi = prod_hi + acc_reg[2];
                lo = prod_lo + acc_reg[0];
            end
            default:
            begin
                hi = acc_reg[5] ^ acc_reg[3] ^ acc_reg[2];
                lo = acc_reg[4] ^ acc_reg[1] ^ acc_reg[0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                acc_reg[k] <= ccc_pkg::seed_of(ccc_pkg::VAR_RESET);
            end
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < 6; k++)
            begin
                acc_reg[k] <= acc_next[k];
            end
            cnt_reg <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_code_reg  <= {hi, lo};
            out_count_reg <= cnt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_count = out_count_reg;

endmodule

`default_nettype wire

FILE: src/cartridge_check_code_engine.sv
`default_nettype none

// Channel   Dir  Beat contents
// s_axis    in   tuser: func; tdata: data_word, table_index (zero padded to 40 bits)
// m_axis    out  tdata: boot code, words_counted (zero padded to 88 bits)
// cfg       in   cfg_wr_en / cfg_wr_data: chip_variant, written on any edge with enable
//
// One beat per cycle sustained on s_axis while the front is not stalled. A start or data
// beat passes the staging register, then the queue, before it reaches the accumulators;
// a table beat is written into the mix table at its own accepting edge. A finish beat
// passes the staging register and the queue and is captured in the output register,
// which raises m_axis_tvalid; the output register lets the next beats enter while a
// result waits. The front stalls only when the 4-deep queue is full; the back stalls
// only on a finish beat while the output register is held.
// Reset: async, active low; accumulators reset to the 6102 seed, count to zero,
// variant to 6102. The mix table has no reset and holds junk until loaded.

module cartridge_check_code_engine #(
    parameter int MAX_WORDS = 262144
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // config
    input  wire logic           cfg_wr_en,
    input  wire logic [2:0]     cfg_wr_data,    // chip_variant
    // slave side
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [39:0]    s_axis_tdata,   // [31:0] data_word, [37:32] table_index
    input  wire logic [1:0]     s_axis_tuser,   // [1:0] func
    // master side
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [87:0]         m_axis_tdata    // [63:0] boot code, [82:64] words_counted
);

    logic [2:0]       variant_reg;
    logic             fq_valid, fq_ready, qb_valid, qb_ready;
    ccc_pkg::q_item_t fq_item, qb_item;
    logic [63:0]      code;
    logic [18:0]      count;

    // live variant register, read by the back on start, data and finish beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= ccc_pkg::VAR_RESET;
        end
        else if (cfg_wr_en)
        begin
            variant_reg <= cfg_wr_data;
        end
    end

    // front: accepts beats, owns the mix table and fetches the slot per data word
    ccc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (ccc_pkg::func_e_t'(s_axis_tuser)),
        .in_data   (s_axis_tdata[31:0]),
        .in_index  (s_axis_tdata[37:32]),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    // decoupling queue
    ccc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // back: accumulators, word count, combine and output register
    ccc_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .variant   (variant_reg),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_code  (code),
        .out_count (count)
    );

    assign m_axis_tdata = {5'd0, count, code};

endmodule

`default_nettype wire
